### rtl/core/mtrf_pkg.sv
// Package: constants, state encoding and control types of the multitouch report framer.
`default_nettype none
package mtrf_pkg;
	localparam int MAX_POINTS = 5;
	localparam int SLOT_W = 3;
	localparam int ID_W = 5;
	localparam int POS_W = 12;
	localparam int ST_W = 2;

	localparam logic [3:0] PKT_LEN = 4'd10;
	localparam logic [7:0] HDR_MTOUCH = 8'h04;
	localparam logic [1:0] CNT_PASS = 2'd1;

	localparam logic [ST_W-1:0] ST_UP = 2'd0;
	localparam logic [ST_W-1:0] ST_DOWN = 2'd1;
	localparam logic [ST_W-1:0] ST_INACTIVE = 2'd2;

	typedef enum logic [0:0] {
		S_IDLE,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan;
	} cmd_t;

	typedef struct packed {
		logic emit_frame;
		logic out_free;
		logic done;
	} sts_t;
endpackage
`default_nettype wire

### rtl/core/mtrf_datapath.sv
// Datapath: packet decode, slot table, decimation counter, frame scan and output register.
`default_nettype none
module mtrf_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mtrf_pkg::cmd_t                cmd,
	output mtrf_pkg::sts_t                     sts,
	input  wire logic [3:0]                    packet_length,
	input  wire logic [7:0]                    report_id,
	input  wire logic [7:0]                    contact_byte,
	input  wire logic [15:0]                   x_raw,
	input  wire logic [15:0]                   y_raw,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mtrf_pkg::SLOT_W-1:0]        slot,
	output logic                               touching,
	output logic [mtrf_pkg::POS_W-1:0]         pos_x,
	output logic [mtrf_pkg::POS_W-1:0]         pos_y,
	output logic                               slot_valid,
	output logic                               frame_end
);
	logic [mtrf_pkg::ST_W-1:0]   status_q [mtrf_pkg::MAX_POINTS];
	logic [mtrf_pkg::POS_W-1:0]  sx_q [mtrf_pkg::MAX_POINTS];
	logic [mtrf_pkg::POS_W-1:0]  sy_q [mtrf_pkg::MAX_POINTS];
	logic [mtrf_pkg::SLOT_W-1:0] last_q;
	logic [1:0]                  count_q;
	logic [mtrf_pkg::SLOT_W-1:0] idx_q;
	logic                        out_valid_q;

	logic [mtrf_pkg::ID_W-1:0]   contact_id;
	logic                        touch;
	logic                        pkt_ok;
	logic [1:0]                  cnt_next;
	logic [mtrf_pkg::MAX_POINTS-1:0] active;
	logic [mtrf_pkg::MAX_POINTS-1:0] rem;
	logic [mtrf_pkg::MAX_POINTS-1:0] later;
	logic                        cur_act;
	logic [mtrf_pkg::ST_W-1:0]   cur_st;
	logic [mtrf_pkg::POS_W-1:0]  cur_x;
	logic [mtrf_pkg::POS_W-1:0]  cur_y;
	logic                        rest_empty;
	logic                        emit;

	assign contact_id = contact_byte[6:2];
	assign touch = contact_byte[0];
	assign pkt_ok = (packet_length == mtrf_pkg::PKT_LEN) && (report_id == mtrf_pkg::HDR_MTOUCH)
		&& (contact_id < mtrf_pkg::ID_W'(mtrf_pkg::MAX_POINTS));
	assign cnt_next = count_q + 2'd1;

	always_comb begin
		active = '0;
		rem = '0;
		later = '0;
		cur_act = 1'b0;
		cur_st = mtrf_pkg::ST_INACTIVE;
		cur_x = '0;
		cur_y = '0;
		for (int i = 0; i < mtrf_pkg::MAX_POINTS; i++) begin
			active[i] = ~status_q[i][1];
			rem[i] = active[i] && (mtrf_pkg::SLOT_W'(i) >= idx_q);
			later[i] = active[i] && (mtrf_pkg::SLOT_W'(i) > idx_q);
			if (mtrf_pkg::SLOT_W'(i) == idx_q) begin
				cur_act = active[i];
				cur_st = status_q[i];
				cur_x = sx_q[i];
				cur_y = sy_q[i];
			end
		end
	end

	assign rest_empty = (rem == '0);
	assign emit = cmd.scan && (rest_empty || cur_act);

	always_comb begin
		sts.emit_frame = pkt_ok && (!touch || ((cnt_next == mtrf_pkg::CNT_PASS)
			&& (contact_id <= mtrf_pkg::ID_W'(last_q))));
		sts.out_free = !out_valid_q || out_ready;
		sts.done = cmd.scan && (rest_empty || (cur_act && (later == '0)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mtrf_pkg::MAX_POINTS; i++) begin
				status_q[i] <= mtrf_pkg::ST_UP;
				sx_q[i] <= '0;
				sy_q[i] <= '0;
			end
			last_q <= '0;
			count_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.accept) begin
				idx_q <= '0;
				if (pkt_ok) begin
					for (int i = 0; i < mtrf_pkg::MAX_POINTS; i++) begin
						if (contact_id == mtrf_pkg::ID_W'(i)) begin
							status_q[i] <= {1'b0, touch};
							sx_q[i] <= x_raw[15:4];
							sy_q[i] <= y_raw[15:4];
						end
					end
					last_q <= contact_id[mtrf_pkg::SLOT_W-1:0];
					count_q <= cnt_next;
				end
			end else if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
				for (int i = 0; i < mtrf_pkg::MAX_POINTS; i++) begin
					if ((mtrf_pkg::SLOT_W'(i) == idx_q) && (status_q[i] == mtrf_pkg::ST_UP)) begin
						status_q[i] <= mtrf_pkg::ST_INACTIVE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (rest_empty) begin
				slot <= '0;
				touching <= 1'b0;
				pos_x <= '0;
				pos_y <= '0;
				slot_valid <= 1'b0;
				frame_end <= 1'b1;
			end else begin
				slot <= idx_q;
				touching <= cur_st[0];
				pos_x <= cur_x;
				pos_y <= cur_y;
				slot_valid <= 1'b1;
				frame_end <= (later == '0);
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

### rtl/core/mtrf_ctrl.sv
// Controller: idle/scan sequencing of packet intake and frame emission.
`default_nettype none
module mtrf_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire mtrf_pkg::sts_t sts,
	output mtrf_pkg::cmd_t      cmd
);
	mtrf_pkg::state_t state_q;
	mtrf_pkg::state_t state_nx;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			mtrf_pkg::S_IDLE: begin
				if (in_valid && sts.emit_frame) begin
					state_nx = mtrf_pkg::S_SCAN;
				end
			end
			mtrf_pkg::S_SCAN: begin
				if (sts.done) begin
					state_nx = mtrf_pkg::S_IDLE;
				end
			end
			default: state_nx = mtrf_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			mtrf_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			mtrf_pkg::S_SCAN: begin
				cmd.scan = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtrf_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end
endmodule
`default_nettype wire

### rtl/core/multitouch_report_framer_top.sv
// Top level of the multitouch report framer.
// Usage:
//   Input channel (in_valid/in_ready) takes one touch packet per item: length,
//   header, contact byte and raw X/Y. Packets with a bad length or header, or a
//   contact id of MAX_POINTS or more, are dropped without effect.
//   A valid packet updates its slot when it is taken. When it triggers a frame,
//   the controller walks the slot table one slot per cycle while the output
//   register (out_valid/out_ready) is free and hands each active slot to it;
//   the last item carries frame_end. An empty frame is a single item with
//   slot_valid low and frame_end high.
//   A packet that emits nothing is taken every cycle; one that emits a frame
//   holds in_ready low during the slot walk, which advances only when the output
//   register is free. The next packet is taken while the last item still waits.
//   Reset: all slots are up at position 0, so the first frame lists all slots;
//   the decimation counter and last contact id clear to zero.
`default_nettype none
module multitouch_report_framer_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [3:0]                    packet_length,
	input  wire logic [7:0]                    report_id,
	input  wire logic [7:0]                    contact_byte,
	input  wire logic [15:0]                   x_raw,
	input  wire logic [15:0]                   y_raw,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mtrf_pkg::SLOT_W-1:0]        slot,
	output logic                               touching,
	output logic [mtrf_pkg::POS_W-1:0]         pos_x,
	output logic [mtrf_pkg::POS_W-1:0]         pos_y,
	output logic                               slot_valid,
	output logic                               frame_end
);
	mtrf_pkg::cmd_t cmd;
	mtrf_pkg::sts_t sts;

	mtrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mtrf_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.packet_length (packet_length),
		.report_id     (report_id),
		.contact_byte  (contact_byte),
		.x_raw         (x_raw),
		.y_raw         (y_raw),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.slot          (slot),
		.touching      (touching),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.slot_valid    (slot_valid),
		.frame_end     (frame_end)
	);
endmodule
`default_nettype wire

### rtl/core/mtrf_checker.sv
// Port-level checker of the multitouch report framer and its bind.
`default_nettype none
module mtrf_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic [3:0]                  packet_length,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [mtrf_pkg::SLOT_W-1:0] slot,
	input wire logic [mtrf_pkg::POS_W-1:0]  pos_x,
	input wire logic [mtrf_pkg::POS_W-1:0]  pos_y,
	input wire logic                        slot_valid,
	input wire logic                        frame_end
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(pos_x)
			&& $stable(pos_y) && $stable(frame_end))
		else $error("output item changed while stalled");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !slot_valid |-> frame_end)
		else $error("empty frame item without frame_end");

	a_busy_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> !in_ready)
		else $error("input taken in the middle of a frame");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && slot_valid |-> slot < mtrf_pkg::SLOT_W'(mtrf_pkg::MAX_POINTS))
		else $error("slot index out of range");

	a_bad_len_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (packet_length != mtrf_pkg::PKT_LEN) |=> in_ready)
		else $error("dropped packet started a frame");
endmodule

bind multitouch_report_framer_top mtrf_checker u_mtrf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.packet_length (packet_length),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.slot          (slot),
	.pos_x         (pos_x),
	.pos_y         (pos_y),
	.slot_valid    (slot_valid),
	.frame_end     (frame_end)
);
`default_nettype wire

### dv/multitouch_report_framer_top_tb.sv
// Testbench for the multitouch report framer: directed and random touch packets, checked per slot item.
module multitouch_report_framer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 180;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 30;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [3:0]  len;
		logic [7:0]  rid;
		logic [7:0]  cb;
		logic [15:0] xr;
		logic [15:0] yr;
	} packet_t;

	// quiet: no item may come out of this packet
	typedef struct packed {
		packet_t pkt;
		bit      quiet;
	} step_t;

	typedef struct packed {
		logic [mtrf_pkg::SLOT_W-1:0] slot;
		logic                        touching;
		logic [mtrf_pkg::POS_W-1:0]  pos_x;
		logic [mtrf_pkg::POS_W-1:0]  pos_y;
		logic                        slot_valid;
		logic                        frame_end;
	} slot_report_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [3:0] packet_length;
	logic [7:0] report_id;
	logic [7:0] contact_byte;
	logic [15:0] x_raw;
	logic [15:0] y_raw;
	logic out_valid;
	logic out_ready;
	logic [mtrf_pkg::SLOT_W-1:0] slot;
	logic touching;
	logic [mtrf_pkg::POS_W-1:0] pos_x;
	logic [mtrf_pkg::POS_W-1:0] pos_y;
	logic slot_valid;
	logic frame_end;

	multitouch_report_framer_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.packet_length(packet_length),
		.report_id(report_id),
		.contact_byte(contact_byte),
		.x_raw(x_raw),
		.y_raw(y_raw),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.slot(slot),
		.touching(touching),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.slot_valid(slot_valid),
		.frame_end(frame_end)
	);

	// shadow of the slot table
	logic [mtrf_pkg::ST_W-1:0]  slot_st [mtrf_pkg::MAX_POINTS];
	logic [mtrf_pkg::POS_W-1:0] slot_px [mtrf_pkg::MAX_POINTS];
	logic [mtrf_pkg::POS_W-1:0] slot_py [mtrf_pkg::MAX_POINTS];
	logic [mtrf_pkg::SLOT_W-1:0] prev_id;
	logic [1:0] pace_cnt;

	slot_report_t pending_reports[$];
	int failures = 0;
	int packets_sent = 0;
	int reports_seen = 0;
	int cycles = 0;

	step_t dir_steps [20] = '{
		'{'{4'd10, 8'h04, 8'h01, 16'hFFFF, 16'h0000}, 1'b0},
		'{'{4'd9,  8'h04, 8'h01, 16'h1234, 16'h5678}, 1'b1},
		'{'{4'd15, 8'h04, 8'h01, 16'h1234, 16'h5678}, 1'b1},
		'{'{4'd0,  8'h04, 8'h01, 16'h1234, 16'h5678}, 1'b1},
		'{'{4'd10, 8'h05, 8'h01, 16'h1234, 16'h5678}, 1'b1},
		'{'{4'd10, 8'hFF, 8'h01, 16'h1234, 16'h5678}, 1'b1},
		'{'{4'd10, 8'h00, 8'h01, 16'h1234, 16'h5678}, 1'b1},
		'{'{4'd10, 8'h04, 8'h15, 16'hFFFF, 16'hFFFF}, 1'b1},
		'{'{4'd10, 8'h04, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1},
		'{'{4'd10, 8'h04, 8'h7C, 16'hFFFF, 16'hFFFF}, 1'b1},
		'{'{4'd10, 8'h04, 8'h05, 16'h000F, 16'hFFF0}, 1'b1},
		'{'{4'd10, 8'h04, 8'h09, 16'hABCD, 16'h0010}, 1'b1},
		'{'{4'd10, 8'h04, 8'h0D, 16'hFFF0, 16'h000F}, 1'b1},
		'{'{4'd10, 8'h04, 8'h11, 16'h0010, 16'hFFFF}, 1'b1},
		'{'{4'd10, 8'h04, 8'h10, 16'h8000, 16'h7FFF}, 1'b0},
		'{'{4'd10, 8'h04, 8'h82, 16'h0000, 16'hFFFF}, 1'b0},
		'{'{4'd10, 8'h04, 8'h83, 16'h5555, 16'hAAAA}, 1'b1},
		'{'{4'd10, 8'h04, 8'h03, 16'hAAAA, 16'h5555}, 1'b0},
		'{'{4'd10, 8'h04, 8'h7D, 16'h1111, 16'h2222}, 1'b1},
		'{'{4'd10, 8'h04, 8'h0C, 16'hFEDC, 16'h0123}, 1'b0}
	};

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		failures++;
	endtask

	// runs one packet through the shadow table; queues the slot items it reports when queue_it is set
	function automatic int track_packet(packet_t p, bit queue_it);
		slot_report_t r;
		logic touch;
		int id;
		int last;
		int n;
		if (p.len != mtrf_pkg::PKT_LEN || p.rid != mtrf_pkg::HDR_MTOUCH)
			return 0;
		touch = p.cb[0];
		id = int'(p.cb[6:2]);
		if (id >= mtrf_pkg::MAX_POINTS)
			return 0;
		slot_st[id] = {1'b0, touch};
		slot_px[id] = p.xr[15:4];
		slot_py[id] = p.yr[15:4];
		last = int'(prev_id);
		prev_id = id[mtrf_pkg::SLOT_W-1:0];
		pace_cnt = pace_cnt + 2'd1;
		if (pace_cnt != mtrf_pkg::CNT_PASS && touch)
			return 0;
		if (touch && id > last)
			return 0;
		n = 0;
		for (int i = 0; i < mtrf_pkg::MAX_POINTS; i++) begin
			if (slot_st[i] == mtrf_pkg::ST_UP || slot_st[i] == mtrf_pkg::ST_DOWN) begin
				r.slot = i[mtrf_pkg::SLOT_W-1:0];
				r.touching = (slot_st[i] == mtrf_pkg::ST_DOWN);
				r.pos_x = slot_px[i];
				r.pos_y = slot_py[i];
				r.slot_valid = 1'b1;
				r.frame_end = 1'b0;
				if (queue_it)
					pending_reports.push_back(r);
				n++;
				if (slot_st[i] == mtrf_pkg::ST_UP)
					slot_st[i] = mtrf_pkg::ST_INACTIVE;
			end
		end
		if (n == 0) begin
			r = '0;
			r.frame_end = 1'b1;
			if (queue_it)
				pending_reports.push_back(r);
			n = 1;
		end else if (queue_it) begin
			pending_reports[pending_reports.size()-1].frame_end = 1'b1;
		end
		return n;
	endfunction

	// every fourth run of 25 items goes without gaps
	function automatic int pick_gap(int n);
		if ((n / 25) % 4 == 3)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	function automatic packet_t random_packet();
		packet_t p;
		p.xr = 16'($urandom());
		p.yr = 16'($urandom());
		if ($urandom_range(0, 9) < 8) begin
			p.len = mtrf_pkg::PKT_LEN;
			p.rid = mtrf_pkg::HDR_MTOUCH;
			p.cb = 8'($urandom());
			p.cb[6:2] = 5'($urandom_range(0, mtrf_pkg::MAX_POINTS - 1));
			p.cb[0] = ($urandom_range(0, 9) < 6);
		end else begin
			p.len = 4'($urandom_range(0, 15));
			p.rid = $urandom_range(0, 1) ? mtrf_pkg::HDR_MTOUCH : 8'($urandom());
			p.cb = 8'($urandom());
		end
		return p;
	endfunction

	// entered and left just after a falling edge
	task automatic offer_packet(input packet_t p, input bit quiet);
		int gap;
		gap = pick_gap(packets_sent);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		packet_length <= p.len;
		report_id <= p.rid;
		contact_byte <= p.cb;
		x_raw <= p.xr;
		y_raw <= p.yr;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		void'(track_packet(p, !quiet));
		packets_sent++;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		slot_report_t want;
		if (arst_n && out_valid && out_ready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected item slot=%0d touching=%0b x=%0d y=%0d v=%0b end=%0b",
					slot, touching, pos_x, pos_y, slot_valid, frame_end));
			end else begin
				want = pending_reports.pop_front();
				if (slot !== want.slot || touching !== want.touching || pos_x !== want.pos_x ||
					pos_y !== want.pos_y || slot_valid !== want.slot_valid ||
					frame_end !== want.frame_end)
					report_mismatch($sformatf(
						"got slot=%0d t=%0b x=%0d y=%0d v=%0b end=%0b, want slot=%0d t=%0b x=%0d y=%0d v=%0b end=%0b",
						slot, touching, pos_x, pos_y, slot_valid, frame_end,
						want.slot, want.touching, want.pos_x, want.pos_y,
						want.slot_valid, want.frame_end));
			end
		end
	end

	// receiver; one long hold-off lets the block back up into its input
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = pick_gap(reports_seen);
			if (!held && reports_seen >= HOLD_AFTER) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		packet_t p;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		packet_length <= '0;
		report_id <= '0;
		contact_byte <= '0;
		x_raw <= '0;
		y_raw <= '0;
		for (int i = 0; i < mtrf_pkg::MAX_POINTS; i++) begin
			slot_st[i] = mtrf_pkg::ST_UP;
			slot_px[i] = '0;
			slot_py[i] = '0;
		end
		prev_id = '0;
		pace_cnt = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k < $size(dir_steps); k++)
			offer_packet(dir_steps[k].pkt, dir_steps[k].quiet);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			p = random_packet();
			offer_packet(p, 1'b0);
		end
		in_valid <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_reports.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
